### rtl/complex_fixed_point_alu_defines.svh
// Assertion macros used by the checker file of the complex fixed-point ALU.
`ifndef COMPLEX_FIXED_POINT_ALU_DEFINES_SVH
`define COMPLEX_FIXED_POINT_ALU_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define CFPA_ASSERT_NOW(label, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error("cfpa assertion failed");

// Property that must hold in the cycle after its trigger.
`define CFPA_ASSERT_NEXT(label, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("cfpa assertion failed");

`endif

### rtl/cfpa_pkg.sv
// Types, constants and stage records of the complex fixed-point ALU.
package cfpa_pkg;

  localparam int W     = 32;             // value width
  localparam int F     = 16;             // fraction bits
  localparam int PW    = 2 * W;          // product width
  localparam int NW    = PW + F;         // shifted dividend width
  localparam int SW    = W + 2;          // first root remainder width
  localparam int R2Q   = (W + F + 2) / 2; // second root width
  localparam int R2W   = 2 * R2Q;        // second root radicand width
  localparam int R2R   = R2Q + 2;        // second root remainder width
  localparam int IN_W  = 136;            // input word width
  localparam int OUT_W = 72;             // output word width

  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_SQRT = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_OVF     = 2'd2
  } status_t;

  // Record carried through the divide and first square root steps.
  typedef struct packed {
    op_t             op;
    logic [W-1:0]    pre_re;
    logic [W-1:0]    pre_im;
    logic            pre_ovf;
    logic [W-1:0]    a;
    logic            b_neg;
    logic            den_zero;
    logic [PW-1:0]   den;
    logic            big_re;
    logic            big_im;
    logic            neg_re;
    logic            neg_im;
    logic [PW-1:0]   drem_re;
    logic [PW-1:0]   drem_im;
    logic [W-1:0]    dlo_re;
    logic [W-1:0]    dlo_im;
    logic [W-1:0]    dq_re;
    logic [W-1:0]    dq_im;
    logic [PW-1:0]   rad;
    logic [SW-1:0]   srem;
    logic [W-1:0]    sroot;
  } iter_t;

  // Record carried through the second pair of square roots.
  typedef struct packed {
    op_t             op;
    logic [W-1:0]    res_re;
    logic [W-1:0]    res_im;
    status_t         st;
    logic            b_neg;
    logic [R2W-1:0]  rad_p;
    logic [R2W-1:0]  rad_n;
    logic [R2R-1:0]  rem_p;
    logic [R2R-1:0]  rem_n;
    logic [R2Q-1:0]  root_p;
    logic [R2Q-1:0]  root_n;
  } root_t;

endpackage

### rtl/complex_fixed_point_alu.sv
// Complex fixed-point ALU top level: stream ports and pipeline hookup.
//
// Input word on s_*: an operation code (add, subtract, multiply, divide,
// square root of the first operand) and two complex operands in signed
// Q16.16. Output word on m_*: the complex result, saturated per part, and
// a status (ok, divide by zero, overflow).
// The pipeline is 62 stages long: three front stages for the products,
// sums and divider setup, 32 stages that each produce one quotient bit of
// both divides and one bit of the magnitude root, one selection stage,
// 25 stages for the two half-angle roots and the output register.
// Every operation takes the same path, so results leave in input order,
// and a new word is taken every cycle unless the pipeline holds.
// The whole pipeline advances together; it holds when the output register
// is full and m_tready is low, and s_tready is low exactly then.
// Reset empties every stage; no result is lost or repeated under stalls.
module complex_fixed_point_alu import cfpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // operation[2:0], first_real[34:3], first_imag[66:35],
  // second_real[98:67], second_imag[130:99], zero padding above
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // result_real[31:0], result_imag[63:32], status[65:64], zero padding above
  output logic [OUT_W-1:0] m_tdata
);

  logic  en;
  logic  f_v, i_v, r_v;
  iter_t f_out, i_out;
  root_t r_out;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  cfpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .op        (op_t'(s_tdata[2:0])),
    .ar        (s_tdata[34:3]),
    .ai        (s_tdata[66:35]),
    .br        (s_tdata[98:67]),
    .bi        (s_tdata[130:99]),
    .out_valid (f_v),
    .out       (f_out)
  );

  cfpa_iter u_iter (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_v),
    .in        (f_out),
    .out_valid (i_v),
    .out       (i_out)
  );

  cfpa_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (i_v),
    .in        (i_out),
    .out_valid (r_v),
    .out       (r_out)
  );

  cfpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_v),
    .in        (r_out),
    .out_valid (m_tvalid),
    .out_word  (m_tdata)
  );

endmodule

### rtl/cfpa_front.sv
// Front stages: operand products, sums, rounding and divider setup.
module cfpa_front import cfpa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  op_t                 op,
  input  logic signed [W-1:0] ar,
  input  logic signed [W-1:0] ai,
  input  logic signed [W-1:0] br,
  input  logic signed [W-1:0] bi,
  output logic                out_valid,
  output iter_t               out
);

  typedef struct packed {
    op_t                op;
    logic [W-1:0]       a;
    logic               b_neg;
    logic signed [W:0]  sum_re;
    logic signed [W:0]  sum_im;
    logic signed [PW-1:0] ac, bd, ad, bc, aa, bb, cc, dd;
  } f1_t;

  typedef struct packed {
    op_t                op;
    logic [W-1:0]       a;
    logic               b_neg;
    logic [W-1:0]       pre_re;
    logic [W-1:0]       pre_im;
    logic               pre_ovf;
    logic signed [PW:0] mre, mim, nre, nim;
    logic [PW-1:0]      den;
    logic [PW-1:0]      rad;
  } f2_t;

  // Clamp a signed value to the W-bit range; top bit flags a clamp.
  function automatic logic [W:0] sat(input logic signed [PW:0] x);
    logic signed [PW:0] hi, lo;
    hi = {{(PW-W+1){1'b0}}, SMAX};
    lo = {{(PW-W+1){1'b1}}, SMIN};
    if (x > hi)      sat = {1'b1, SMAX};
    else if (x < lo) sat = {1'b1, SMIN};
    else             sat = {1'b0, x[W-1:0]};
  endfunction

  logic  v1, v2;
  f1_t   s1, s1_next;
  f2_t   s2, s2_next;
  iter_t s3_next;

  always_comb begin
    s1_next.op     = op;
    s1_next.a      = ar;
    s1_next.b_neg  = ai[W-1];
    if (op == OP_SUB) begin
      s1_next.sum_re = (W+1)'(ar) - (W+1)'(br);
      s1_next.sum_im = (W+1)'(ai) - (W+1)'(bi);
    end else begin
      s1_next.sum_re = (W+1)'(ar) + (W+1)'(br);
      s1_next.sum_im = (W+1)'(ai) + (W+1)'(bi);
    end
    s1_next.ac = ar * br;
    s1_next.bd = ai * bi;
    s1_next.ad = ar * bi;
    s1_next.bc = ai * br;
    s1_next.aa = ar * ar;
    s1_next.bb = ai * ai;
    s1_next.cc = br * br;
    s1_next.dd = bi * bi;
  end

  always_comb begin
    logic [W:0] sr, si;
    sr = sat((PW+1)'(s1.sum_re));
    si = sat((PW+1)'(s1.sum_im));
    s2_next.op      = s1.op;
    s2_next.a       = s1.a;
    s2_next.b_neg   = s1.b_neg;
    s2_next.pre_re  = sr[W-1:0];
    s2_next.pre_im  = si[W-1:0];
    s2_next.pre_ovf = sr[W] | si[W];
    s2_next.mre = (PW+1)'(s1.ac) - (PW+1)'(s1.bd);
    s2_next.mim = (PW+1)'(s1.ad) + (PW+1)'(s1.bc);
    s2_next.nre = (PW+1)'(s1.ac) + (PW+1)'(s1.bd);
    s2_next.nim = (PW+1)'(s1.bc) - (PW+1)'(s1.ad);
    s2_next.den = PW'(s1.cc) + PW'(s1.dd);
    s2_next.rad = PW'(s1.aa) + PW'(s1.bb);
  end

  always_comb begin
    logic signed [PW:0] rre, rim, mag_re, mag_im;
    logic [W:0]         qr, qi;
    logic [NW-1:0]      nr, ni;
    rre = (s2.mre + ((PW+1)'(1) <<< (F-1))) >>> F;
    rim = (s2.mim + ((PW+1)'(1) <<< (F-1))) >>> F;
    qr  = sat(rre);
    qi  = sat(rim);
    mag_re = s2.nre[PW] ? -s2.nre : s2.nre;
    mag_im = s2.nim[PW] ? -s2.nim : s2.nim;
    nr = {mag_re[PW-1:0], {F{1'b0}}};
    ni = {mag_im[PW-1:0], {F{1'b0}}};
    s3_next.op = s2.op;
    if (s2.op == OP_MUL) begin
      s3_next.pre_re  = qr[W-1:0];
      s3_next.pre_im  = qi[W-1:0];
      s3_next.pre_ovf = qr[W] | qi[W];
    end else begin
      s3_next.pre_re  = s2.pre_re;
      s3_next.pre_im  = s2.pre_im;
      s3_next.pre_ovf = s2.pre_ovf;
    end
    s3_next.a        = s2.a;
    s3_next.b_neg    = s2.b_neg;
    s3_next.den_zero = (s2.den == '0);
    s3_next.den      = s2.den;
    // A quotient of 2**W or more only decides saturation.
    s3_next.big_re   = PW'(nr[NW-1:W]) >= s2.den;
    s3_next.big_im   = PW'(ni[NW-1:W]) >= s2.den;
    s3_next.neg_re   = s2.nre[PW];
    s3_next.neg_im   = s2.nim[PW];
    s3_next.drem_re  = PW'(nr[NW-1:W]);
    s3_next.drem_im  = PW'(ni[NW-1:W]);
    s3_next.dlo_re   = nr[W-1:0];
    s3_next.dlo_im   = ni[W-1:0];
    s3_next.dq_re    = '0;
    s3_next.dq_im    = '0;
    s3_next.rad      = s2.rad;
    s3_next.srem     = '0;
    s3_next.sroot    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1  <= s1_next;
      s2  <= s2_next;
      out <= s3_next;
    end
  end

endmodule

### rtl/cfpa_iter.sv
// Quotient and magnitude root stages: one bit of each per stage.
module cfpa_iter import cfpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  iter_t in,
  output logic  out_valid,
  output iter_t out
);

  function automatic iter_t iter_step(input iter_t x);
    iter_t         y;
    logic [PW:0]   r_re, r_im, dd;
    logic [SW+1:0] sr, trial;
    y  = x;
    dd = {1'b0, x.den};
    r_re = {x.drem_re, x.dlo_re[W-1]};
    r_im = {x.drem_im, x.dlo_im[W-1]};
    y.dlo_re = x.dlo_re << 1;
    y.dlo_im = x.dlo_im << 1;
    if (r_re >= dd) begin
      y.drem_re = PW'(r_re - dd);
      y.dq_re   = {x.dq_re[W-2:0], 1'b1};
    end else begin
      y.drem_re = r_re[PW-1:0];
      y.dq_re   = {x.dq_re[W-2:0], 1'b0};
    end
    if (r_im >= dd) begin
      y.drem_im = PW'(r_im - dd);
      y.dq_im   = {x.dq_im[W-2:0], 1'b1};
    end else begin
      y.drem_im = r_im[PW-1:0];
      y.dq_im   = {x.dq_im[W-2:0], 1'b0};
    end
    // Digit-by-digit root: two radicand bits in, one root bit out.
    sr    = {x.srem, x.rad[PW-1 -: 2]};
    trial = (SW+2)'({x.sroot, 2'b01});
    if (sr >= trial) begin
      y.srem  = SW'(sr - trial);
      y.sroot = {x.sroot[W-2:0], 1'b1};
    end else begin
      y.srem  = sr[SW-1:0];
      y.sroot = {x.sroot[W-2:0], 1'b0};
    end
    y.rad = x.rad << 2;
    return y;
  endfunction

  iter_t st  [W];
  logic  vld [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    iter_t prev;
    logic  prev_v;
    if (i == 0) begin : g_first
      assign prev   = in;
      assign prev_v = in_valid;
    end else begin : g_rest
      assign prev   = st[i-1];
      assign prev_v = vld[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i] <= iter_step(prev);
      end
    end
  end

  assign out       = st[W-1];
  assign out_valid = vld[W-1];

endmodule

### rtl/cfpa_root.sv
// Divide result selection, then the two half-angle root stages.
module cfpa_root import cfpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  iter_t in,
  output logic  out_valid,
  output root_t out
);

  function automatic logic [W:0] div_sat(input logic big, input logic neg,
                                         input logic [W-1:0] q);
    if (big)             div_sat = {1'b1, neg ? SMIN : SMAX};
    else if (!neg)       div_sat = q[W-1] ? {1'b1, SMAX} : {1'b0, q};
    else if (q > SMIN)   div_sat = {1'b1, SMIN};
    else                 div_sat = {1'b0, W'(-q)};
  endfunction

  function automatic root_t root_step(input root_t x);
    root_t          y;
    logic [R2R+1:0] sp, sn, tp, tn;
    y  = x;
    sp = {x.rem_p, x.rad_p[R2W-1 -: 2]};
    sn = {x.rem_n, x.rad_n[R2W-1 -: 2]};
    tp = (R2R+2)'({x.root_p, 2'b01});
    tn = (R2R+2)'({x.root_n, 2'b01});
    if (sp >= tp) begin
      y.rem_p  = R2R'(sp - tp);
      y.root_p = {x.root_p[R2Q-2:0], 1'b1};
    end else begin
      y.rem_p  = sp[R2R-1:0];
      y.root_p = {x.root_p[R2Q-2:0], 1'b0};
    end
    if (sn >= tn) begin
      y.rem_n  = R2R'(sn - tn);
      y.root_n = {x.root_n[R2Q-2:0], 1'b1};
    end else begin
      y.rem_n  = sn[R2R-1:0];
      y.root_n = {x.root_n[R2Q-2:0], 1'b0};
    end
    y.rad_p = x.rad_p << 2;
    y.rad_n = x.rad_n << 2;
    return y;
  endfunction

  root_t mid, mid_next;
  logic  mid_v;

  always_comb begin
    logic [W:0]   dr, di;
    logic [W+1:0] sp, sn;
    dr = div_sat(in.big_re, in.neg_re, in.dq_re);
    di = div_sat(in.big_im, in.neg_im, in.dq_im);
    mid_next.op    = in.op;
    mid_next.b_neg = in.b_neg;
    mid_next.res_re = '0;
    mid_next.res_im = '0;
    mid_next.st     = ST_OK;
    case (in.op)
      OP_ADD, OP_SUB, OP_MUL: begin
        mid_next.res_re = in.pre_re;
        mid_next.res_im = in.pre_im;
        mid_next.st     = in.pre_ovf ? ST_OVF : ST_OK;
      end
      OP_DIV: begin
        if (in.den_zero) begin
          mid_next.st = ST_DIVZERO;
        end else begin
          mid_next.res_re = dr[W-1:0];
          mid_next.res_im = di[W-1:0];
          mid_next.st     = (dr[W] | di[W]) ? ST_OVF : ST_OK;
        end
      end
      default: begin
      end
    endcase
    // The magnitude root is never below |a|, so both sums are non-negative.
    sp = {2'b00, in.sroot} + {{2{in.a[W-1]}}, in.a};
    sn = {2'b00, in.sroot} - {{2{in.a[W-1]}}, in.a};
    mid_next.rad_p  = R2W'({sp, {F{1'b0}}} >> 1);
    mid_next.rad_n  = R2W'({sn, {F{1'b0}}} >> 1);
    mid_next.rem_p  = '0;
    mid_next.rem_n  = '0;
    mid_next.root_p = '0;
    mid_next.root_n = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_v <= 1'b0;
    end else if (en) begin
      mid_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid <= mid_next;
    end
  end

  root_t st  [R2Q];
  logic  vld [R2Q];

  for (genvar i = 0; i < R2Q; i++) begin : g_stage
    root_t prev;
    logic  prev_v;
    if (i == 0) begin : g_first
      assign prev   = mid;
      assign prev_v = mid_v;
    end else begin : g_rest
      assign prev   = st[i-1];
      assign prev_v = vld[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i] <= root_step(prev);
      end
    end
  end

  assign out       = st[R2Q-1];
  assign out_valid = vld[R2Q-1];

endmodule

### rtl/cfpa_back.sv
// Output stage: final result selection into the output register.
module cfpa_back import cfpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  root_t            in,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_word
);

  logic [OUT_W-1:0] word_next;

  always_comb begin
    logic [W-1:0] re, im, rn;
    status_t      st;
    rn = W'(in.root_n);
    if (in.op == OP_SQRT) begin
      re = W'(in.root_p);
      im = in.b_neg ? W'(-rn) : rn;
      st = ST_OK;
    end else begin
      re = in.res_re;
      im = in.res_im;
      st = in.st;
    end
    word_next = OUT_W'({st, im, re});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

### rtl/cfpa_checker.sv
// Port-level checks for the complex fixed-point ALU, bound to the top level.
`include "complex_fixed_point_alu_defines.svh"

module cfpa_checker import cfpa_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // A held word keeps its value until taken.
  `CFPA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // An empty output register always lets the pipeline move.
  `CFPA_ASSERT_NOW(a_ready, !m_tvalid, s_tready)
  `CFPA_ASSERT_NOW(a_status, m_tvalid, m_tdata[65:64] != 2'd3)
  // Divide by zero always returns zero.
  `CFPA_ASSERT_NOW(a_dz, m_tvalid && (m_tdata[65:64] == ST_DIVZERO), m_tdata[63:0] == '0)

endmodule

bind complex_fixed_point_alu cfpa_checker u_cfpa_checker (.*);
